// ===== src/pkcd_pkg.sv =====
// pkcd_pkg: shared types and constants of the prefix key command decoder
// no dependencies; imported by every module of the block
`default_nettype none

package pkcd_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_META_PREFIX = 2'd0;
    localparam logic [1:0] CFG_IDX_CTLX_PREFIX = 2'd1;
    localparam logic [1:0] CFG_IDX_SEQ_ENABLE  = 2'd2;

    // configuration reset values
    localparam logic [7:0] RST_META_PREFIX = 8'd27;
    localparam logic [7:0] RST_CTLX_PREFIX = 8'd24;
    localparam logic       RST_SEQ_ENABLE  = 1'b1;

    // character constants
    localparam logic [7:0] CTL_MAX        = 8'h1F;
    localparam logic [7:0] CTL_OFFSET     = 8'h40;
    localparam logic [7:0] CASE_BIT       = 8'h20;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_UPPER_O   = 8'h4F;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_B   = 8'h42;
    localparam logic [7:0] CHAR_UPPER_C   = 8'h43;
    localparam logic [7:0] CHAR_UPPER_D   = 8'h44;
    localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
    localparam logic [7:0] CHAR_UPPER_N   = 8'h4E;
    localparam logic [7:0] CHAR_UPPER_P   = 8'h50;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;

    // configuration as seen by the decoder
    typedef struct packed {
        logic [7:0] meta_prefix_byte;
        logic [7:0] ctlx_prefix_byte;
        logic       cursor_seq_enable;
    } t_cfg;

    // one decoded command
    typedef struct packed {
        logic       ctl_flag;
        logic       meta_flag;
        logic       ctlx_flag;
        logic [7:0] key_char;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/pkcd_if.sv =====
// pkcd_if: handshake channels of the prefix key command decoder
// key byte input, command output and configuration write channel
`default_nettype none

// raw key bytes
interface pkcd_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;

    modport source (output valid, output key_byte, input ready);
    modport sink   (input valid, input key_byte, output ready);
endinterface

// decoded commands
interface pkcd_cmd_if;
    logic       valid;
    logic       ready;
    logic       ctl_flag;
    logic       meta_flag;
    logic       ctlx_flag;
    logic [7:0] key_char;

    modport source (output valid, output ctl_flag, output meta_flag,
                    output ctlx_flag, output key_char, input ready);
    modport sink   (input valid, input ctl_flag, input meta_flag,
                    input ctlx_flag, input key_char, output ready);
endinterface

// register writes
interface pkcd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/prefix_key_command_decoder.sv =====
// prefix_key_command_decoder: top level, key bytes in, decoded commands out
// depends on pkcd_pkg, pkcd_if, pkcd_cfg_regs, pkcd_core, pkcd_out_reg
//
//   channel   dir   payload                                   handshake
//   i_key     in    key_byte[7:0]                             valid/ready
//   o_cmd     out   ctl_flag, meta_flag, ctlx_flag, key_char  valid/ready
//   i_cfg     in    index[1:0], data[7:0]                     valid/ready
//
// one key byte per cycle while o_cmd is not stalled; each byte is held in
// the input register, then its command, if any, in the result register
// prefix bytes move the prefix state and usually produce no command
// a stall on o_cmd holds the result register and then the input register
// synchronous active-low reset clears the state and the valids
// configuration writes are always ready
`default_nettype none

module prefix_key_command_decoder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pkcd_key_if.sink    i_key,
    pkcd_cmd_if.source  o_cmd,
    pkcd_cfg_if.sink    i_cfg
);
    import pkcd_pkg::*;

    t_cfg w_cfg;
    logic w_res_valid;
    t_cmd w_res;
    logic w_res_ready;
    logic w_out_valid;
    t_cmd w_out;

    // configuration
    assign i_cfg.ready = 1'b1;

    pkcd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    // decode
    pkcd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_key.valid),
        .i_in_byte   (i_key.key_byte),
        .o_in_ready  (i_key.ready),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // result register
    pkcd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_data  (w_res),
        .o_ready (w_res_ready),
        .o_valid (w_out_valid),
        .o_data  (w_out),
        .i_ready (o_cmd.ready)
    );

    assign o_cmd.valid     = w_out_valid;
    assign o_cmd.ctl_flag  = w_out.ctl_flag;
    assign o_cmd.meta_flag = w_out.meta_flag;
    assign o_cmd.ctlx_flag = w_out.ctlx_flag;
    assign o_cmd.key_char  = w_out.key_char;

endmodule

`default_nettype wire

// ===== src/pkcd_cfg_regs.sv =====
// pkcd_cfg_regs: configuration registers of the prefix key command decoder
// depends on pkcd_pkg
`default_nettype none

module pkcd_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_valid,
    input  wire logic [1:0]    i_wr_index,
    input  wire logic [7:0]    i_wr_data,
    output pkcd_pkg::t_cfg     o_cfg
);
    import pkcd_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.meta_prefix_byte  <= RST_META_PREFIX;
            r_cfg.ctlx_prefix_byte  <= RST_CTLX_PREFIX;
            r_cfg.cursor_seq_enable <= RST_SEQ_ENABLE;
        end else if (i_wr_valid) begin
            case (i_wr_index)
                CFG_IDX_META_PREFIX: r_cfg.meta_prefix_byte  <= i_wr_data;
                CFG_IDX_CTLX_PREFIX: r_cfg.ctlx_prefix_byte  <= i_wr_data;
                CFG_IDX_SEQ_ENABLE:  r_cfg.cursor_seq_enable <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/pkcd_core.sv =====
// pkcd_core: input register, prefix state and single-pass decode
// depends on pkcd_pkg
`default_nettype none

module pkcd_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [7:0]    i_in_byte,
    output logic               o_in_ready,
    input  wire pkcd_pkg::t_cfg i_cfg,
    output logic               o_res_valid,
    output pkcd_pkg::t_cmd     o_res,
    input  wire logic          i_res_ready
);
    import pkcd_pkg::*;

    // prefix state codes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_META = 2'd1;
    localparam logic [1:0] MODE_CTLX = 2'd2;
    localparam logic [1:0] MODE_CSI  = 2'd3;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [1:0] r_mode, n_mode;
    logic       r_meta, n_meta;
    logic       r_ctlx, n_ctlx;

    logic       w_adv;
    logic       w_ctl;
    logic [7:0] w_ch;
    logic       w_is_meta;
    logic       w_is_ctlx;
    logic       w_emit;
    logic       w_fold;
    logic [7:0] w_char;
    t_cmd       w_cmd;

    // the held byte moves on when the result side can take it
    assign w_adv      = r_in_valid && i_res_ready;
    assign o_in_ready = !r_in_valid || i_res_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    // control folding and prefix compare
    assign w_ctl     = (r_in_byte <= CTL_MAX);
    assign w_ch      = w_ctl ? (r_in_byte + CTL_OFFSET) : r_in_byte;
    assign w_is_meta = (r_in_byte == i_cfg.meta_prefix_byte);
    assign w_is_ctlx = (r_in_byte == i_cfg.ctlx_prefix_byte);

    // lower case folding after a prefix
    assign w_fold = (r_mode == MODE_META) || (r_mode == MODE_CTLX);
    assign w_char = (w_fold && !w_ctl && (w_ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}))
                    ? (w_ch ^ CASE_BIT) : w_ch;

    // prefix state machine
    always_comb begin
        n_mode = r_mode;
        n_meta = r_meta;
        n_ctlx = r_ctlx;
        w_emit = 1'b0;
        w_cmd  = '{ctl_flag: w_ctl, meta_flag: r_meta, ctlx_flag: r_ctlx,
                   key_char: w_char};
        case (r_mode)
            MODE_IDLE: begin
                if (w_is_meta) begin
                    n_mode = MODE_META;
                end else if (w_is_ctlx) begin
                    n_mode = MODE_CTLX;
                end else begin
                    w_emit          = 1'b1;
                    w_cmd.meta_flag = 1'b0;
                    w_cmd.ctlx_flag = 1'b0;
                end
            end
            MODE_META: begin
                if (i_cfg.cursor_seq_enable &&
                    (r_in_byte == CHAR_LBRACKET || r_in_byte == CHAR_UPPER_O)) begin
                    n_mode = MODE_CSI;
                end else begin
                    n_meta = 1'b1;
                    if (i_cfg.cursor_seq_enable && w_is_meta) begin
                        n_mode = MODE_META;
                    end else if (w_is_ctlx) begin
                        n_mode = MODE_CTLX;
                    end else begin
                        w_emit          = 1'b1;
                        w_cmd.meta_flag = 1'b1;
                    end
                end
            end
            MODE_CTLX: begin
                n_ctlx = 1'b1;
                if (w_is_meta) begin
                    n_mode = MODE_META;
                end else begin
                    w_emit          = 1'b1;
                    w_cmd.ctlx_flag = 1'b1;
                end
            end
            MODE_CSI: begin
                w_emit         = 1'b1;
                w_cmd.ctl_flag = 1'b1;
                case (r_in_byte)
                    CHAR_UPPER_A: w_cmd.key_char = CHAR_UPPER_P;
                    CHAR_UPPER_B: w_cmd.key_char = CHAR_UPPER_N;
                    CHAR_UPPER_C: w_cmd.key_char = CHAR_UPPER_F;
                    CHAR_UPPER_D: w_cmd.key_char = CHAR_UPPER_B;
                    default: begin
                        w_cmd.meta_flag = 1'b1;
                        w_cmd.ctlx_flag = 1'b1;
                        w_cmd.key_char  = CHAR_UPPER_Z;
                    end
                endcase
            end
            default: ;
        endcase
        // a command closes the sequence
        if (w_emit) begin
            n_mode = MODE_IDLE;
            n_meta = 1'b0;
            n_ctlx = 1'b0;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_meta <= 1'b0;
            r_ctlx <= 1'b0;
        end else if (w_adv) begin
            r_mode <= n_mode;
            r_meta <= n_meta;
            r_ctlx <= n_ctlx;
        end
    end

    assign o_res_valid = r_in_valid && w_emit;
    assign o_res       = w_cmd;

endmodule

`default_nettype wire

// ===== src/pkcd_out_reg.sv =====
// pkcd_out_reg: result register in front of the command channel
// depends on pkcd_pkg
`default_nettype none

module pkcd_out_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire pkcd_pkg::t_cmd i_data,
    output logic               o_ready,
    output logic               o_valid,
    output pkcd_pkg::t_cmd     o_data,
    input  wire logic          i_ready
);
    import pkcd_pkg::*;

    logic r_valid;
    t_cmd r_data;

    // takes a new item when empty or when the held one leaves
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire
